// ===== design/assert_macros.svh =====
// Assertion helpers; clk and rst_n must be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/itu_pkg.sv =====
`default_nettype none
package itu_pkg;

  typedef struct packed {
    logic               command;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } itu_in_t;

  typedef struct packed {
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [31:0] tilt_x;
    logic signed [31:0] tilt_y;
    logic signed [31:0] yaw_angle;
  } itu_out_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 3'd4;

  localparam logic [15:0] SCALE_RST = 16'd16768;
  localparam logic [12:0] RATE_RST  = 13'd250;

  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 29;
  localparam int DIV_CNT_W = 6;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } itu_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
  } itu_div_rsp_t;

  localparam int CORDIC_STEPS = 20;
  localparam int SQRT_STEPS   = 24;

  localparam logic signed [31:0] HALF_Q16     = 32'sd11796480;
  localparam logic signed [31:0] NEG_HALF_Q16 = -32'sd11796480;
  localparam logic signed [31:0] FULL_Q16     = 32'sd23592960;
  localparam logic signed [31:0] QUART_Q16    = 32'sd5898240;
  localparam logic signed [31:0] NEG_QUART    = -32'sd5898240;
  localparam logic signed [33:0] SIN_X0       = 34'sd652032874;

  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117305;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    logic signed [31:0] r;
    if (v > 43'sd2147483647) r = 32'sh7fffffff;
    else if (v < -43'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/imu_tilt_and_gyro_integrator.sv =====
// Channel | Signals                          | Transaction
// input   | in_valid, in_ready, in_data      | one frame or one copy command
// output  | out_valid, out_ready, out_data   | rates, tilts and yaw
// config  | cfg_we, cfg_index, cfg_wdata     | one register write, no wait
// A copy command skips the arithmetic; a frame runs through the shared
// restoring divider (six 40-step divisions), the 24-step square root and the
// 20-step CORDIC, run at most twice for tilt and once for the yaw sine.
// in_ready is high only while the sequencer is idle; one item at a time.
// A result waits in the output register; a stalled output holds the sequencer.
// rst_n is synchronous and clears the angles and restores register defaults.
`default_nettype none
module imu_tilt_and_gyro_integrator (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  itu_pkg::itu_in_t        in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output itu_pkg::itu_out_t       out_data,
  input  logic                    cfg_we,
  input  logic [itu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [itu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  `include "assert_macros.svh"

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_SCMUL   = 5'd1;
  localparam logic [4:0] ST_SCSTORE = 5'd2;
  localparam logic [4:0] ST_DIVGO   = 5'd3;
  localparam logic [4:0] ST_DIVWAIT = 5'd4;
  localparam logic [4:0] ST_SQA     = 5'd5;
  localparam logic [4:0] ST_SQB     = 5'd6;
  localparam logic [4:0] ST_SQC     = 5'd7;
  localparam logic [4:0] ST_SQRT    = 5'd8;
  localparam logic [4:0] ST_ATAN    = 5'd9;
  localparam logic [4:0] ST_UPD     = 5'd10;
  localparam logic [4:0] ST_MODGO   = 5'd11;
  localparam logic [4:0] ST_MODWAIT = 5'd12;
  localparam logic [4:0] ST_WRAP    = 5'd13;
  localparam logic [4:0] ST_FOLD    = 5'd14;
  localparam logic [4:0] ST_SIN     = 5'd15;
  localparam logic [4:0] ST_P1      = 5'd16;
  localparam logic [4:0] ST_P2      = 5'd17;
  localparam logic [4:0] ST_P3      = 5'd18;
  localparam logic [4:0] ST_P4      = 5'd19;
  localparam logic [4:0] ST_OUT     = 5'd20;

  // full turn in Q16.16 is 45 * 2^19; quotient by 45 via 2^20 reciprocal
  localparam logic [14:0] MOD_RECIP = 15'd23302;
  localparam logic [12:0] MOD_TURNS = 13'd45;

  logic signed [15:0] ofs_x_r, ofs_y_r, ofs_z_r;
  logic [15:0]        scale_r;
  logic [12:0]        rate_hz_r;

  logic [4:0]         state_r;
  itu_pkg::itu_in_t   in_r;
  logic               out_valid_r;
  itu_pkg::itu_out_t  out_data_r;

  logic signed [31:0] roll_r, pitch_r, heading_r, held_x_r, held_y_r;
  logic signed [31:0] res_r [6];
  logic [2:0]         k_r;
  logic               j_r;
  logic [4:0]         cnt_r;
  logic [itu_pkg::DIV_DEN_W-1:0] divp_r;

  logic signed [63:0] prod_r;
  logic signed [31:0] mul_a, mul_b;
  logic [31:0]        sq_r;

  logic [47:0]        sqv_r;
  logic [24:0]        srem_r;
  logic [23:0]        root_r;
  logic [26:0]        rem_sh, trial, sdiff;
  logic [23:0]        root_nxt;
  logic [24:0]        srem_nxt;

  logic signed [33:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [31:0] z_r, z_nxt, ang_r, s_r, at;
  logic               vec_r, pos;

  logic signed [16:0] dx, dy, dz, d_sel;
  logic               d_neg;
  logic [16:0]        d_mag;
  logic [15:0]        sc;
  logic [12:0]        fr;
  logic signed [32:0] a_ext;
  logic               a_neg;
  logic [31:0]        a_mag;
  logic [12:0]        mod_hi, mod_rem;
  logic [18:0]        mod_lo;
  logic [27:0]        mod_prod;
  logic [6:0]         mq_r;
  logic signed [42:0] qv;
  logic [31:0]        sq_sum;
  logic signed [15:0] a1;

  itu_pkg::itu_div_req_t div_req;
  itu_pkg::itu_div_rsp_t div_rsp;

  itu_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_x_r   <= '0;
      ofs_y_r   <= '0;
      ofs_z_r   <= '0;
      scale_r   <= itu_pkg::SCALE_RST;
      rate_hz_r <= itu_pkg::RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        itu_pkg::CFG_OFS_X: ofs_x_r   <= cfg_wdata;
        itu_pkg::CFG_OFS_Y: ofs_y_r   <= cfg_wdata;
        itu_pkg::CFG_OFS_Z: ofs_z_r   <= cfg_wdata;
        itu_pkg::CFG_SCALE: scale_r   <= cfg_wdata;
        itu_pkg::CFG_RATE:  rate_hz_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  assign dx = 17'(in_r.gyro_x) - 17'(ofs_x_r);
  assign dy = 17'(in_r.gyro_y) - 17'(ofs_y_r);
  assign dz = 17'(in_r.gyro_z) - 17'(ofs_z_r);
  assign sc = (scale_r == '0) ? 16'd1 : scale_r;
  assign fr = (rate_hz_r == '0) ? 13'd1 : rate_hz_r;

  always_comb begin
    case (k_r)
      3'd0, 3'd3: d_sel = dx;
      3'd1, 3'd4: d_sel = dy;
      default:    d_sel = dz;
    endcase
  end
  assign d_neg = d_sel[16];
  assign d_mag = d_neg ? 17'(-d_sel) : 17'(d_sel);

  assign a_ext = 33'(res_r[5]);
  assign a_neg = a_ext[32];
  assign a_mag = a_neg ? 32'(-a_ext) : 32'(a_ext);

  assign mod_hi   = a_mag[31:19];
  assign mod_lo   = a_mag[18:0];
  assign mod_prod = 28'(mod_hi) * 28'(MOD_RECIP);
  assign mod_rem  = mod_hi - 13'(mq_r) * MOD_TURNS;

  assign qv = d_neg ? -$signed({3'b0, div_rsp.quo}) : $signed({3'b0, div_rsp.quo});

  always_comb begin
    div_req.start = (state_r == ST_DIVGO);
    div_req.num   = {d_mag[15:0], 24'b0};
    div_req.den   = (k_r < 3'd3) ? {13'b0, sc} : divp_r;
  end

  assign a1 = j_r ? in_r.accel_y : in_r.accel_x;

  always_comb begin
    case (state_r)
      ST_SCMUL: begin
        mul_a = {19'b0, fr};
        mul_b = {16'b0, sc};
      end
      ST_SQA: begin
        mul_a = 32'(a1);
        mul_b = 32'(a1);
      end
      ST_SQB: begin
        mul_a = 32'(in_r.accel_z);
        mul_b = 32'(in_r.accel_z);
      end
      ST_P1: begin
        mul_a = roll_r;
        mul_b = s_r;
      end
      ST_P3: begin
        mul_a = pitch_r;
        mul_b = s_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sq_sum = sq_r + prod_r[31:0];

  // square root digit step
  assign rem_sh   = {srem_r, sqv_r[47:46]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign sdiff    = rem_sh - trial;
  assign root_nxt = {root_r[22:0], rem_sh >= trial};
  assign srem_nxt = (rem_sh >= trial) ? sdiff[24:0] : rem_sh[24:0];

  // CORDIC micro-rotation, vectoring or rotation
  assign xs  = x_r >>> cnt_r;
  assign ys  = y_r >>> cnt_r;
  assign at  = itu_pkg::atan_deg(cnt_r);
  assign pos = vec_r ? !y_r[33] : !z_r[31];
  always_comb begin
    if (vec_r == pos) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end
    if (!vec_r) begin
      x_nxt = pos ? x_r - ys : x_r + ys;
      y_nxt = pos ? y_r + xs : y_r - xs;
      z_nxt = pos ? z_r - at : z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      roll_r      <= '0;
      pitch_r     <= '0;
      heading_r   <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            in_r <= in_data;
            k_r  <= '0;
            j_r  <= 1'b0;
            if (in_data.command) begin
              roll_r  <= held_x_r;
              pitch_r <= held_y_r;
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_SCMUL;
            end
          end
        end
        ST_SCMUL:   state_r <= ST_SCSTORE;
        ST_SCSTORE: begin
          divp_r  <= prod_r[itu_pkg::DIV_DEN_W-1:0];
          state_r <= ST_DIVGO;
        end
        ST_DIVGO:   state_r <= ST_DIVWAIT;
        ST_DIVWAIT: begin
          if (div_rsp.done) begin
            res_r[k_r] <= itu_pkg::sat32(qv);
            if (k_r == 3'd5) begin
              state_r <= ST_SQA;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= ST_DIVGO;
            end
          end
        end
        ST_SQA: state_r <= ST_SQB;
        ST_SQB: begin
          sq_r    <= prod_r[31:0];
          state_r <= ST_SQC;
        end
        ST_SQC: begin
          if (sq_sum == '0) begin
            j_r     <= 1'b1;
            state_r <= j_r ? ST_UPD : ST_SQA;
          end else begin
            sqv_r   <= {sq_sum, 16'b0};
            srem_r  <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          sqv_r  <= {sqv_r[45:0], 2'b00};
          srem_r <= srem_nxt;
          root_r <= root_nxt;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == 5'(itu_pkg::SQRT_STEPS - 1)) begin
            x_r     <= 34'({1'b0, root_nxt});
            y_r     <= {{10{in_r.accel_x[15]}}, 16'(j_r ? in_r.accel_x : in_r.accel_y), 8'b0};
            z_r     <= '0;
            vec_r   <= 1'b1;
            cnt_r   <= '0;
            state_r <= ST_ATAN;
          end
          if (cnt_r == 5'(itu_pkg::SQRT_STEPS - 1) && !j_r) begin
            y_r <= {{10{in_r.accel_y[15]}}, in_r.accel_y, 8'b0};
          end
        end
        ST_ATAN: begin
          x_r   <= x_nxt;
          y_r   <= y_nxt;
          z_r   <= z_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'(itu_pkg::CORDIC_STEPS - 1)) begin
            if (j_r) begin
              held_y_r <= z_nxt;
              state_r  <= ST_UPD;
            end else begin
              held_x_r <= z_nxt;
              j_r      <= 1'b1;
              state_r  <= ST_SQA;
            end
          end
        end
        ST_UPD: begin
          roll_r    <= itu_pkg::sat32(43'(roll_r) + 43'(res_r[3]));
          pitch_r   <= itu_pkg::sat32(43'(pitch_r) - 43'(res_r[4]));
          heading_r <= itu_pkg::sat32(43'(heading_r) - 43'(res_r[5]));
          state_r   <= ST_MODGO;
        end
        ST_MODGO: begin
          mq_r    <= mod_prod[26:20];
          state_r <= ST_MODWAIT;
        end
        ST_MODWAIT: begin
          ang_r   <= a_neg ? -$signed({7'b0, mod_rem[5:0], mod_lo})
                           : $signed({7'b0, mod_rem[5:0], mod_lo});
          state_r <= ST_WRAP;
        end
        ST_WRAP: begin
          if (ang_r >= itu_pkg::HALF_Q16) ang_r <= ang_r - itu_pkg::FULL_Q16;
          else if (ang_r < itu_pkg::NEG_HALF_Q16) ang_r <= ang_r + itu_pkg::FULL_Q16;
          state_r <= ST_FOLD;
        end
        ST_FOLD: begin
          if (ang_r > itu_pkg::QUART_Q16) z_r <= itu_pkg::HALF_Q16 - ang_r;
          else if (ang_r < itu_pkg::NEG_QUART) z_r <= itu_pkg::NEG_HALF_Q16 - ang_r;
          else z_r <= ang_r;
          x_r     <= itu_pkg::SIN_X0;
          y_r     <= '0;
          vec_r   <= 1'b0;
          cnt_r   <= '0;
          state_r <= ST_SIN;
        end
        ST_SIN: begin
          x_r   <= x_nxt;
          y_r   <= y_nxt;
          z_r   <= z_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'(itu_pkg::CORDIC_STEPS - 1)) begin
            s_r     <= y_nxt[31:0];
            state_r <= ST_P1;
          end
        end
        ST_P1: state_r <= ST_P2;
        ST_P2: begin
          pitch_r <= itu_pkg::sat32(43'(pitch_r) + 43'(prod_r >>> 30));
          state_r <= ST_P3;
        end
        ST_P3: state_r <= ST_P4;
        ST_P4: begin
          roll_r  <= itu_pkg::sat32(43'(roll_r) - 43'(prod_r >>> 30));
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r          <= 1'b1;
            out_data_r.rate_x    <= in_r.command ? '0 : res_r[0];
            out_data_r.rate_y    <= in_r.command ? '0 : res_r[1];
            out_data_r.rate_z    <= in_r.command ? '0 : res_r[2];
            out_data_r.tilt_x    <= held_x_r;
            out_data_r.tilt_y    <= held_y_r;
            out_data_r.yaw_angle <= heading_r;
            state_r              <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_cmd_short, in_valid && in_ready && in_data.command, state_r == ST_OUT)
  `ASSERT_IMPL(a_div_done_wait, div_rsp.done, state_r == ST_DIVWAIT)
  `ASSERT_NEXT(a_out_load, state_r == ST_OUT && (!out_valid_r || out_ready),
               out_valid_r && state_r == ST_IDLE)

endmodule
`default_nettype wire

// ===== design/itu_div.sv =====
`default_nettype none
module itu_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itu_pkg::itu_div_req_t req,
  output itu_pkg::itu_div_rsp_t rsp
);

  logic                             busy_r;
  logic                             done_r;
  logic [itu_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [itu_pkg::DIV_NUM_W-1:0]    n_r;
  logic [itu_pkg::DIV_DEN_W-1:0]    rem_r;
  logic [itu_pkg::DIV_DEN_W-1:0]    den_r;
  logic [itu_pkg::DIV_DEN_W:0]      rem_sh;
  logic [itu_pkg::DIV_DEN_W:0]      diff;
  logic                             fits;

  assign rem_sh = {rem_r, n_r[itu_pkg::DIV_NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        n_r    <= req.num;
        rem_r  <= '0;
        den_r  <= req.den;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= diff[itu_pkg::DIV_DEN_W-1:0];
          n_r   <= {n_r[itu_pkg::DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[itu_pkg::DIV_DEN_W-1:0];
          n_r   <= {n_r[itu_pkg::DIV_NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == itu_pkg::DIV_CNT_W'(itu_pkg::DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = n_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ===== sim/tb_imu_tilt_and_gyro_integrator.sv =====
`default_nettype none
module tb_imu_tilt_and_gyro_integrator;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  itu_pkg::itu_in_t in_data;
  logic out_valid;
  logic out_ready;
  itu_pkg::itu_out_t out_data;
  logic cfg_we;
  logic [itu_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [itu_pkg::CFG_DATA_W-1:0] cfg_wdata;

  imu_tilt_and_gyro_integrator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    itu_pkg::itu_in_t  item;
    bit                typed;
    itu_pkg::itu_out_t want;
  } plan_row_t;

  localparam longint ARCTAN_DEG[20] = '{
    2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  // predictor state and register shadow
  longint roll_q, pitch_q, heading_q, tilt_x_q, tilt_y_q;
  logic signed [15:0] ofs_x, ofs_y, ofs_z;
  logic [15:0] scale_q8;
  logic [12:0] frame_hz;

  itu_pkg::itu_out_t pending_results[$];
  int errors = 0;
  bit hold_req = 0;
  bit no_idle = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #100ms;
    $display("imu_tilt_and_gyro_integrator regression: fail");
    $finish;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vec_atan(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ARCTAN_DEG[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ARCTAN_DEG[i];
      end
    end
    return z;
  endfunction

  function automatic longint sine_q30(longint a);
    longint half, quarter, r, x, y, z, xs, ys;
    half = 64'sd11796480;
    quarter = half / 2;
    r = a % (2 * half);
    if (r >= half) r = r - 2 * half;
    if (r < -half) r = r + 2 * half;
    if (r > quarter) r = half - r;
    if (r < -quarter) r = -half - r;
    x = 64'sd652032874;
    y = 0;
    z = r;
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ARCTAN_DEG[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ARCTAN_DEG[i];
      end
    end
    return y;
  endfunction

  function automatic itu_pkg::itu_out_t predict_attitude(itu_pkg::itu_in_t f);
    itu_pkg::itu_out_t o;
    longint ax, ay, az, dx, dy, dz, sc, fr, dv, up;
    longint rx, ry, rz, stx, sty, stz, roll, pitch, s, sxz, syz;
    rx = 0; ry = 0; rz = 0;
    if (f.command) begin
      roll_q = tilt_x_q;
      pitch_q = tilt_y_q;
    end else begin
      ax = f.accel_x; ay = f.accel_y; az = f.accel_z;
      dx = longint'(f.gyro_x) - longint'(ofs_x);
      dy = longint'(f.gyro_y) - longint'(ofs_y);
      dz = longint'(f.gyro_z) - longint'(ofs_z);
      sc = (scale_q8 == 0) ? 1 : longint'(scale_q8);
      fr = (frame_hz == 0) ? 1 : longint'(frame_hz);
      dv = fr * sc;
      up = 64'sd16777216;
      rx = clamp32(dx * up / sc);
      ry = clamp32(dy * up / sc);
      rz = clamp32(dz * up / sc);
      sxz = ax * ax + az * az;
      syz = ay * ay + az * az;
      if (sxz > 0) tilt_x_q = clamp32(vec_atan(ay * 256, longint'(root64(sxz << 16))));
      if (syz > 0) tilt_y_q = clamp32(vec_atan(ax * 256, longint'(root64(syz << 16))));
      stx = clamp32(dx * up / dv);
      sty = clamp32(dy * up / dv);
      stz = clamp32(dz * up / dv);
      roll = clamp32(roll_q + stx);
      pitch = clamp32(pitch_q - sty);
      heading_q = clamp32(heading_q - stz);
      s = sine_q30(stz);
      pitch = clamp32(pitch + ((roll * s) >>> 30));
      roll = clamp32(roll - ((pitch * s) >>> 30));
      roll_q = roll;
      pitch_q = pitch;
    end
    o.rate_x = rx[31:0];
    o.rate_y = ry[31:0];
    o.rate_z = rz[31:0];
    o.tilt_x = tilt_x_q[31:0];
    o.tilt_y = tilt_y_q[31:0];
    o.yaw_angle = heading_q[31:0];
    return o;
  endfunction

  function automatic itu_pkg::itu_in_t mk(bit cmd, int ax, int ay, int az, int gx, int gy,
                                          int gz);
    itu_pkg::itu_in_t t;
    t.command = cmd;
    t.accel_x = ax[15:0]; t.accel_y = ay[15:0]; t.accel_z = az[15:0];
    t.gyro_x = gx[15:0]; t.gyro_y = gy[15:0]; t.gyro_z = gz[15:0];
    return t;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic int rand_axis();
    int m;
    m = $urandom_range(0, 9);
    case (m)
      0: return 32767;
      1: return -32768;
      2: return 0;
      3: return $urandom_range(0, 1) ? 16384 : -16384;
      4, 5: return $urandom_range(0, 2000) - 1000;
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  function automatic itu_pkg::itu_in_t rand_item();
    itu_pkg::itu_in_t t;
    t.command = ($urandom_range(0, 99) < 8);
    t.accel_x = 16'(rand_axis());
    t.accel_y = 16'(rand_axis());
    t.accel_z = ($urandom_range(0, 3) == 0) ? 16'sd0 : 16'(rand_axis());
    t.gyro_x = 16'($urandom());
    t.gyro_y = 16'($urandom());
    t.gyro_z = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 600) - 300) : 16'($urandom());
    return t;
  endfunction

  task automatic write_reg(logic [itu_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      itu_pkg::CFG_OFS_X: ofs_x = val;
      itu_pkg::CFG_OFS_Y: ofs_y = val;
      itu_pkg::CFG_OFS_Z: ofs_z = val;
      itu_pkg::CFG_SCALE: scale_q8 = val;
      itu_pkg::CFG_RATE:  frame_hz = val[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_frame(itu_pkg::itu_in_t it, bit typed, itu_pkg::itu_out_t want);
    itu_pkg::itu_out_t p;
    int g;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    p = predict_attitude(it);
    pending_results.push_back(typed ? want : p);
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data = '0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    in_data = '0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // result side: random stalls and one long hold-off
  initial begin
    int hold;
    itu_pkg::itu_out_t e;
    logic [191:0] ev, av;
    string fname[6];
    fname = '{"rate_x", "rate_y", "rate_z", "tilt_x", "tilt_y", "yaw_angle"};
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected transaction %h", $realtime, out_data);
          errors++;
        end else begin
          e = pending_results.pop_front();
          ev = e;
          av = out_data;
          for (int k = 0; k < 6; k++)
            if (ev[191 - 32*k -: 32] !== av[191 - 32*k -: 32]) begin
              $display("%0t: %s expected %h actual %h", $realtime, fname[k],
                       ev[191 - 32*k -: 32], av[191 - 32*k -: 32]);
              errors++;
            end
        end
      end
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold = 3000;
      end
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else if (no_idle) begin
        out_ready = 1'b1;
      end else begin
        out_ready = (pick_gap() == 0);
      end
    end
  end

  initial begin
    plan_row_t plan[15];
    itu_pkg::itu_out_t zero_out;
    zero_out = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = itu_pkg::CFG_OFS_X;
    cfg_wdata = '0;
    ofs_x = 0; ofs_y = 0; ofs_z = 0;
    scale_q8 = itu_pkg::SCALE_RST;
    frame_hz = itu_pkg::RATE_RST;
    roll_q = 0; pitch_q = 0; heading_q = 0; tilt_x_q = 0; tilt_y_q = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    plan[0]  = '{mk(1, 0, 0, 0, 0, 0, 0), 1, zero_out};
    plan[1]  = '{mk(0, 0, 0, 0, 0, 0, 0), 1, zero_out};
    plan[2]  = '{mk(0, 0, 0, 16384, 0, 0, 0), 0, zero_out};
    plan[3]  = '{mk(0, 16384, 0, 0, 50, -50, 10), 0, zero_out};
    plan[4]  = '{mk(0, 0, 16384, 0, 0, 0, 0), 0, zero_out};
    plan[5]  = '{mk(0, 0, 0, 0, 100, 100, 100), 0, zero_out};
    plan[6]  = '{mk(0, 32767, -32768, 0, 32767, -32768, 32767), 0, zero_out};
    plan[7]  = '{mk(0, -32768, -32768, -32768, -32768, 32767, -32768), 0, zero_out};
    plan[8]  = '{mk(0, 32767, 32767, 32767, 1, -1, 0), 0, zero_out};
    plan[9]  = '{mk(1, -1, 2, -3, 4, -5, 6), 0, zero_out};
    plan[10] = '{mk(0, 100, -200, 16000, 3000, -4000, 20000), 0, zero_out};
    plan[11] = '{mk(0, 0, 0, -16384, 0, 0, -32768), 0, zero_out};
    plan[12] = '{mk(0, -16384, 16384, 0, -300, 300, 32767), 0, zero_out};
    plan[13] = '{mk(1, 32767, 32767, 32767, 32767, 32767, 32767), 0, zero_out};
    plan[14] = '{mk(0, 1, -1, 1, -1, 1, -1), 0, zero_out};
    foreach (plan[i]) send_frame(plan[i].item, plan[i].typed, plan[i].want);

    for (int ph = 1; ph <= 8; ph++) begin
      drain();
      case (ph)
        1: begin
          write_reg(itu_pkg::CFG_OFS_X, 16'h8000); write_reg(itu_pkg::CFG_OFS_Y, 16'h7fff);
          write_reg(itu_pkg::CFG_OFS_Z, 16'h8000); write_reg(itu_pkg::CFG_SCALE, 16'd1);
          write_reg(itu_pkg::CFG_RATE, 16'd1);
        end
        2: begin
          write_reg(itu_pkg::CFG_OFS_X, 16'h7fff); write_reg(itu_pkg::CFG_OFS_Y, 16'h8000);
          write_reg(itu_pkg::CFG_OFS_Z, 16'h7fff); write_reg(itu_pkg::CFG_SCALE, 16'hffff);
          write_reg(itu_pkg::CFG_RATE, 16'd8000);
        end
        3: begin
          write_reg(itu_pkg::CFG_SCALE, 16'd0); write_reg(itu_pkg::CFG_RATE, 16'd0);
          write_reg(itu_pkg::CFG_OFS_Z, 16'd0);
        end
        default: begin
          write_reg(itu_pkg::CFG_OFS_X, 16'($urandom_range(0, 600) - 300));
          write_reg(itu_pkg::CFG_OFS_Y, 16'($urandom()));
          write_reg(itu_pkg::CFG_OFS_Z, 16'($urandom_range(0, 600) - 300));
          write_reg(itu_pkg::CFG_SCALE, ($urandom_range(0, 1) != 0)
                                        ? 16'($urandom_range(1, 65535))
                                        : 16'($urandom_range(1000, 20000)));
          write_reg(itu_pkg::CFG_RATE, 16'($urandom_range(1, 8000)));
        end
      endcase
      no_idle = (ph == 6);
      if (ph == 4) hold_req = 1;
      for (int n = 0; n < 240; n++) begin
        if (ph == 5 && n == 120) drain();
        send_frame(rand_item(), 0, zero_out);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    in_data = '0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("imu_tilt_and_gyro_integrator regression: pass");
    end else begin
      $display("imu_tilt_and_gyro_integrator regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
